// File: src/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared constants and types of the I2C master transfer engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam logic [7:0] HalfPeriodRst = 8'd20;

  localparam logic [1:0] OpTick  = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusAddrNack = 2'd1;
  localparam logic [1:0] StatusDataNack = 2'd2;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       byte_taken;
    logic [7:0] read_data;
    logic       read_valid;
    logic       done_res;
    logic [1:0] status;
  } i2cm_res_t;

endpackage

// File: src/i2cm_if.sv
// ----------------------------------------------------------------------------
// i2cm_req_if / i2cm_rsp_if
// Valid/ready channels for tick beats in and result beats out.
// ----------------------------------------------------------------------------
interface i2cm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [6:0] dev_address;
  logic [7:0] byte_count;
  logic [7:0] write_data;
  logic       scl_line;
  logic       sda_line;

  modport source (
    output valid, opcode, dev_address, byte_count, write_data, scl_line, sda_line,
    input  ready
  );
  modport sink (
    input  valid, opcode, dev_address, byte_count, write_data, scl_line, sda_line,
    output ready
  );
endinterface

interface i2cm_rsp_if;
  logic       valid;
  logic       ready;
  logic       scl_low;
  logic       sda_low;
  logic       busy_res;
  logic       byte_taken;
  logic [7:0] read_data;
  logic       read_valid;
  logic       done_res;
  logic [1:0] status;

  modport source (
    output valid, scl_low, sda_low, busy_res, byte_taken, read_data, read_valid,
           done_res, status,
    input  ready
  );
  modport sink (
    input  valid, scl_low, sda_low, busy_res, byte_taken, read_data, read_valid,
           done_res, status,
    output ready
  );
endinterface

// File: src/i2c_master_transfer_engine_top.sv
// ----------------------------------------------------------------------------
// i2c_master_transfer_engine_top
// Tick-driven 7-bit I2C master with registered result channel.
//
// Each beat on req_i is one bus tick: it carries the command (plain tick,
// start write, start read), address, byte count, next write byte and the
// sampled SCL/SDA levels. Each accepted beat yields exactly one beat on
// rsp_o with the open-drain drive levels, busy, byte_taken, read byte,
// done and status for that tick.
// The response beat is registered: into out_q, or into the skid while rsp_o stalls.
// Throughput: one beat per cycle; a two-entry output stage (register plus
// skid) keeps req_i.ready high while rsp_o holds a beat, and drops it only
// once two beats wait. req_i.ready is registered, with no path from
// rsp_o.ready.
// cfg_we_i/cfg_wdata_i write half_period (ticks per SCL phase, 0 acts as 1);
// write it only while no transfer is running.
// Reset: sequencer idle, output stage empty, half_period back to 20.
// ----------------------------------------------------------------------------
module i2c_master_transfer_engine_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  i2cm_req_if.sink   req_i,
  i2cm_rsp_if.source rsp_o
);
  import i2cm_pkg::*;

  logic [7:0] half_period_q;
  logic       req_fire;
  i2cm_res_t  res;
  i2cm_res_t  out_q, skid_q;
  logic       out_valid_q, skid_valid_q;

  assign req_i.ready = !skid_valid_q;
  assign req_fire    = req_i.valid && !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HalfPeriodRst;
    end else if (cfg_we_i) begin
      half_period_q <= cfg_wdata_i;
    end
  end

  i2cm_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (req_fire),
    .half_period_i (half_period_q),
    .opcode_i      (req_i.opcode),
    .dev_address_i (req_i.dev_address),
    .byte_count_i  (req_i.byte_count),
    .write_data_i  (req_i.write_data),
    .scl_line_i    (req_i.scl_line),
    .sda_line_i    (req_i.sda_line),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || rsp_o.ready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= req_fire;
      end
    end else if (req_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || rsp_o.ready) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (req_fire) begin
        out_q <= res;
      end
    end else if (req_fire) begin
      skid_q <= res;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.scl_low    = out_q.scl_low;
  assign rsp_o.sda_low    = out_q.sda_low;
  assign rsp_o.busy_res   = out_q.busy_res;
  assign rsp_o.byte_taken = out_q.byte_taken;
  assign rsp_o.read_data  = out_q.read_data;
  assign rsp_o.read_valid = out_q.read_valid;
  assign rsp_o.done_res   = out_q.done_res;
  assign rsp_o.status     = out_q.status;

endmodule

// File: src/i2cm_engine.sv
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer: advances one tick per accepted beat, yields line drive
// and transfer status for that tick.
// ----------------------------------------------------------------------------
module i2cm_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic [7:0]          half_period_i,
  input  logic [1:0]          opcode_i,
  input  logic [6:0]          dev_address_i,
  input  logic [7:0]          byte_count_i,
  input  logic [7:0]          write_data_i,
  input  logic                scl_line_i,
  input  logic                sda_line_i,
  output i2cm_pkg::i2cm_res_t res_o
);
  import i2cm_pkg::*;

  typedef enum logic [4:0] {
    P_IDLE   = 5'd0,
    P_STA_A  = 5'd1,
    P_STA_B  = 5'd2,
    P_ATX_L  = 5'd3,
    P_ATX_H  = 5'd4,
    P_AACK_L = 5'd5,
    P_AACK_H = 5'd6,
    P_DTX_L  = 5'd7,
    P_DTX_H  = 5'd8,
    P_DACK_L = 5'd9,
    P_DACK_H = 5'd10,
    P_RX_L   = 5'd11,
    P_RX_H   = 5'd12,
    P_RACK_L = 5'd13,
    P_RACK_H = 5'd14,
    P_STO_A  = 5'd15,
    P_STO_B  = 5'd16,
    P_STO_C  = 5'd17
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [2:0] bit_index_q, bit_index_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic [7:0] shift_byte_q, shift_byte_d;
  logic [7:0] phase_timer_q, phase_timer_d;
  logic       reading_q, reading_d;
  logic [1:0] result_code_q, result_code_d;

  logic [7:0] hp_eff;
  logic [7:0] timer_inc;
  logic       released;
  logic       stalled;
  logic       over;
  i2cm_res_t  res;

  always_comb begin
    hp_eff    = (half_period_i == 8'd0) ? 8'd1 : half_period_i;
    timer_inc = phase_timer_q + 8'd1;
    released  = phase_q inside {P_STA_A, P_STA_B, P_ATX_H, P_DTX_H, P_AACK_H, P_DACK_H,
                                P_RX_H, P_RACK_H, P_STO_B};
    stalled   = released && !scl_line_i;
    over      = !stalled && (timer_inc >= hp_eff);

    phase_d       = phase_q;
    bit_index_d   = bit_index_q;
    bytes_left_d  = bytes_left_q;
    shift_byte_d  = shift_byte_q;
    reading_d     = reading_q;
    result_code_d = result_code_q;
    phase_timer_d = (phase_q == P_IDLE || stalled) ? phase_timer_q : timer_inc;
    res           = '0;

    case (phase_q)
      P_IDLE: begin
        if (opcode_i == OpWrite || opcode_i == OpRead) begin
          reading_d     = (opcode_i == OpRead);
          bytes_left_d  = byte_count_i;
          shift_byte_d  = {dev_address_i, reading_d};
          bit_index_d   = 3'd0;
          result_code_d = StatusOk;
          phase_d       = P_STA_A;
        end
      end
      P_STA_A:  if (over) phase_d = P_STA_B;
      P_STA_B:  if (over) phase_d = P_ATX_L;
      P_ATX_L:  if (over) phase_d = P_ATX_H;
      P_DTX_L:  if (over) phase_d = P_DTX_H;
      P_AACK_L: if (over) phase_d = P_AACK_H;
      P_DACK_L: if (over) phase_d = P_DACK_H;
      P_RX_L:   if (over) phase_d = P_RX_H;
      P_RACK_L: if (over) phase_d = P_RACK_H;
      P_STO_A:  if (over) phase_d = P_STO_B;
      P_STO_B:  if (over) phase_d = P_STO_C;
      P_ATX_H, P_DTX_H: begin
        if (over) begin
          shift_byte_d = {shift_byte_q[6:0], 1'b0};
          if (bit_index_q == 3'd7) begin
            bit_index_d = 3'd0;
            phase_d     = (phase_q == P_ATX_H) ? P_AACK_L : P_DACK_L;
          end else begin
            bit_index_d = bit_index_q + 3'd1;
            phase_d     = (phase_q == P_ATX_H) ? P_ATX_L : P_DTX_L;
          end
        end
      end
      P_AACK_H, P_DACK_H: begin
        if (over) begin
          if (sda_line_i) begin
            result_code_d = (phase_q == P_AACK_H) ? StatusAddrNack : StatusDataNack;
            phase_d       = P_STO_A;
          end else if (bytes_left_q == 8'd0) begin
            phase_d = P_STO_A;
          end else if (phase_q == P_AACK_H && reading_q) begin
            bit_index_d = 3'd0;
            phase_d     = P_RX_L;
          end else begin
            shift_byte_d   = write_data_i;
            res.byte_taken = 1'b1;
            bytes_left_d   = bytes_left_q - 8'd1;
            bit_index_d    = 3'd0;
            phase_d        = P_DTX_L;
          end
        end
      end
      P_RX_H: begin
        if (over) begin
          shift_byte_d = {shift_byte_q[6:0], sda_line_i};
          if (bit_index_q == 3'd7) begin
            res.read_data  = shift_byte_d;
            res.read_valid = 1'b1;
            bytes_left_d   = bytes_left_q - 8'd1;
            bit_index_d    = 3'd0;
            phase_d        = P_RACK_L;
          end else begin
            bit_index_d = bit_index_q + 3'd1;
            phase_d     = P_RX_L;
          end
        end
      end
      P_RACK_H: if (over) phase_d = (bytes_left_q == 8'd0) ? P_STO_A : P_RX_L;
      P_STO_C: begin
        if (over) begin
          res.done_res = 1'b1;
          res.status   = result_code_q;
          phase_d      = P_IDLE;
        end
      end
      default: phase_d = P_IDLE;
    endcase

    if (phase_d != phase_q) phase_timer_d = 8'd0;

    case (phase_d)
      P_STA_B: begin
        res.scl_low = 1'b0;
        res.sda_low = 1'b1;
      end
      P_ATX_L, P_DTX_L: begin
        res.scl_low = 1'b1;
        res.sda_low = !shift_byte_d[7];
      end
      P_ATX_H, P_DTX_H: begin
        res.scl_low = 1'b0;
        res.sda_low = !shift_byte_d[7];
      end
      P_AACK_L, P_DACK_L, P_RX_L: begin
        res.scl_low = 1'b1;
        res.sda_low = 1'b0;
      end
      P_RACK_L, P_STO_A: begin
        res.scl_low = 1'b1;
        res.sda_low = 1'b1;
      end
      P_RACK_H, P_STO_B: begin
        res.scl_low = 1'b0;
        res.sda_low = 1'b1;
      end
      default: begin
        res.scl_low = 1'b0;
        res.sda_low = 1'b0;
      end
    endcase

    res.busy_res = (phase_d != P_IDLE);
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= P_IDLE;
      bit_index_q   <= 3'd0;
      bytes_left_q  <= 8'd0;
      shift_byte_q  <= 8'd0;
      phase_timer_q <= 8'd0;
      reading_q     <= 1'b0;
      result_code_q <= StatusOk;
    end else if (adv_i) begin
      phase_q       <= phase_d;
      bit_index_q   <= bit_index_d;
      bytes_left_q  <= bytes_left_d;
      shift_byte_q  <= shift_byte_d;
      phase_timer_q <= phase_timer_d;
      reading_q     <= reading_d;
      result_code_q <= result_code_d;
    end
  end

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && res.done_res |=> phase_q == P_IDLE)
    else $error("done without return to idle");

  a_rvalid_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && res.read_valid |-> reading_q)
    else $error("read byte outside a read transfer");

  a_taken_in_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && res.byte_taken |-> !reading_q && (phase_q == P_AACK_H || phase_q == P_DACK_H))
    else $error("write byte taken outside a write ack");

endmodule
